/* hw/rtl/rrjs_pkg.sv */
package rrjs_pkg;

    // Command codes; a result reports the command code as its kind.
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_PROC = 2'd1;
    localparam logic [1:0] CMD_UNLD = 2'd2;

    // Outcome of one process step in the ready ring.
    typedef struct packed {
        logic retire;
        logic admit;
        logic idle;
    } ring_status_t;

endpackage

/* hw/rtl/rrjs_wait_fifo.sv */
module rrjs_wait_fifo
    import rrjs_pkg::*;
#(
    parameter int DEPTH   = 16,
    parameter int ID_W    = 16,
    parameter int TIME_W  = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [ID_W-1:0]   push_id,
    input  logic [TIME_W-1:0] push_time,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output logic [ID_W-1:0]   head_id,
    output logic [TIME_W-1:0] head_time
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [ID_W-1:0]   id_mem   [DEPTH];
    logic [TIME_W-1:0] time_mem [DEPTH];
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW-1:0]     rd_ptr_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [AW-1:0]     wr_slot;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH))
        begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign wr_slot   = wrap_add(rd_ptr_reg, count_reg);
    assign head_id   = id_mem[rd_ptr_reg];
    assign head_time = time_mem[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && not_empty)
        begin
            rd_ptr_next = wrap_add(rd_ptr_reg, CW'(1));
            count_next  = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            id_mem[wr_slot]   <= push_id;
            time_mem[wr_slot] <= push_time;
        end
    end

endmodule

/* hw/rtl/rrjs_done_stack.sv */
module rrjs_done_stack
    import rrjs_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int ID_W  = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic [ID_W-1:0] push_id,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output logic [ID_W-1:0] top_id
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [ID_W-1:0] id_mem [DEPTH];
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [CW-1:0]   top_idx;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign top_idx = count_reg - CW'(1);
    assign top_id  = id_mem[top_idx[AW-1:0]];

    always_comb
    begin
        count_next = count_reg;
        if (push && !full)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !empty)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            id_mem[count_reg[AW-1:0]] <= push_id;
        end
    end

endmodule

/* hw/rtl/rrjs_ready_ring.sv */
module rrjs_ready_ring
    import rrjs_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ID_W   = 16,
    parameter int TIME_W = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              proc,
    input  logic [15:0]       quantum,
    input  logic              wait_valid,
    input  logic [ID_W-1:0]   wait_id,
    input  logic [TIME_W-1:0] wait_time,
    input  logic              stack_full,
    output ring_status_t      status,
    output logic [ID_W-1:0]   tail_id,
    output logic [ID_W-1:0]   run_id,
    output logic [TIME_W-1:0] run_time
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = TIME_W + 16;

    logic [ID_W-1:0]   id_mem   [DEPTH];
    logic [TIME_W-1:0] time_mem [DEPTH];
    logic [AW-1:0]     head_reg;
    logic [CW-1:0]     count_reg;
    // Copy of the entry at the tail, which is always the job rotated last.
    logic [ID_W-1:0]   tail_id_reg;
    logic [TIME_W-1:0] tail_time_reg;

    logic [CW-1:0]     count_1;
    logic [CW-1:0]     count_2;
    logic [ID_W-1:0]   head_id;
    logic [TIME_W-1:0] head_time;
    logic [CMPW-1:0]   head_x;
    logic [CMPW-1:0]   quantum_x;
    logic [CMPW-1:0]   diff;
    logic [AW-1:0]     admit_slot;
    logic [AW-1:0]     rotate_slot;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH))
        begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    always_comb
    begin
        status.retire = proc && (count_reg != '0) && (tail_time_reg == '0) && !stack_full;
        count_1       = count_reg - CW'(status.retire);
        status.admit  = proc && wait_valid && (count_1 != CW'(DEPTH));
        count_2       = count_1 + CW'(status.admit);
        status.idle   = (count_2 == '0);
    end

    // With nothing left in the ring, the head is the job just admitted.
    assign head_id   = (count_1 == '0) ? wait_id   : id_mem[head_reg];
    assign head_time = (count_1 == '0) ? wait_time : time_mem[head_reg];

    assign head_x    = CMPW'(head_time);
    assign quantum_x = CMPW'(quantum);
    assign diff      = head_x - quantum_x;

    assign run_id      = head_id;
    assign run_time    = (head_x <= quantum_x) ? '0 : diff[TIME_W-1:0];
    assign tail_id     = tail_id_reg;
    assign admit_slot  = wrap_add(head_reg, count_1);
    assign rotate_slot = wrap_add(head_reg, count_2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (proc)
        begin
            count_reg <= count_2;
            if (!status.idle)
            begin
                head_reg <= wrap_add(head_reg, CW'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && !status.idle)
        begin
            if (status.admit)
            begin
                id_mem[admit_slot]   <= wait_id;
                time_mem[admit_slot] <= wait_time;
            end
            id_mem[rotate_slot]   <= run_id;
            time_mem[rotate_slot] <= run_time;
            tail_id_reg           <= run_id;
            tail_time_reg         <= run_time;
        end
    end

endmodule

/* hw/rtl/round_robin_job_scheduler_top.sv */
// Channel   Signals                                   Direction  Handshake
// --------  ----------------------------------------  ---------  ----------------------------
// request   start, busy, cmd, job_id, job_time        in         taken when start && !busy
// result    result_strobe, result_kind, load_rejected, out       one-cycle strobe, no stall
//           ring_idle, report_id, remaining_time,
//           stack_empty
// config    cfg_we, cfg_wdata (time quantum)          in         written when cfg_we is high
//
// A request is registered on the edge that takes it, worked through the FIFO, ring and
// stack logic in the next cycle, and its result strobes in the cycle after that: one request
// per cycle, so busy never rises. The rate is set by the single combinational pass from
// the request register into the result register. Reset clears the counts and pointers
// and sets the quantum to one; store contents are not cleared.
// The receiver cannot stall, so nothing back-pressures the request side.
module round_robin_job_scheduler_top
    import rrjs_pkg::*;
#(
    parameter int WAIT_DEPTH  = 16,
    parameter int RING_DEPTH  = 16,
    parameter int STACK_DEPTH = 16,
    parameter int ID_WIDTH    = 16,
    parameter int TIME_WIDTH  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [15:0] job_id,
    input  logic [15:0] job_time,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output logic        result_strobe,
    output logic [1:0]  result_kind,
    output logic        load_rejected,
    output logic        ring_idle,
    output logic [15:0] report_id,
    output logic [15:0] remaining_time,
    output logic        stack_empty
);

    // Request register.
    logic                  req_valid_reg;
    logic [1:0]            cmd_reg;
    logic [ID_WIDTH-1:0]   id_reg;
    logic [TIME_WIDTH-1:0] time_reg;
    logic [15:0]           quantum_reg;

    // Result register.
    logic                  strobe_reg;
    logic [1:0]            kind_reg;
    logic                  rejected_reg;
    logic                  idle_reg;
    logic [ID_WIDTH-1:0]   report_id_reg;
    logic [ID_WIDTH-1:0]   report_id_next;
    logic [TIME_WIDTH-1:0] remaining_reg;
    logic [TIME_WIDTH-1:0] remaining_next;
    logic                  empty_reg;

    // The request fields are kept in their low bits, or zero extended for wider stores.
    logic [ID_WIDTH+15:0]   id_ext;
    logic [TIME_WIDTH+15:0] time_ext;
    logic [ID_WIDTH+15:0]   id_out_ext;
    logic [TIME_WIDTH+15:0] time_out_ext;

    logic is_load;
    logic is_proc;
    logic is_unld;

    logic                  fifo_full;
    logic                  fifo_not_empty;
    logic [ID_WIDTH-1:0]   fifo_id;
    logic [TIME_WIDTH-1:0] fifo_time;
    logic                  stk_full;
    logic                  stk_empty;
    logic [ID_WIDTH-1:0]   stk_top;
    ring_status_t          ring_status;
    logic [ID_WIDTH-1:0]   ring_tail_id;
    logic [ID_WIDTH-1:0]   ring_run_id;
    logic [TIME_WIDTH-1:0] ring_run_time;

    assign busy     = 1'b0;
    assign id_ext   = {(ID_WIDTH)'(0), job_id};
    assign time_ext = {(TIME_WIDTH)'(0), job_time};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            strobe_reg    <= 1'b0;
            quantum_reg   <= 16'd1;
        end
        else
        begin
            req_valid_reg <= start && !busy;
            strobe_reg    <= req_valid_reg;
            if (cfg_we)
            begin
                quantum_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg  <= cmd;
            id_reg   <= id_ext[ID_WIDTH-1:0];
            time_reg <= time_ext[TIME_WIDTH-1:0];
        end
    end

    assign is_load = req_valid_reg && (cmd_reg == CMD_LOAD);
    assign is_proc = req_valid_reg && (cmd_reg == CMD_PROC);
    assign is_unld = req_valid_reg && (cmd_reg == CMD_UNLD);

    rrjs_wait_fifo #(
        .DEPTH  (WAIT_DEPTH),
        .ID_W   (ID_WIDTH),
        .TIME_W (TIME_WIDTH)
    ) u_wait_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (is_load),
        .push_id   (id_reg),
        .push_time (time_reg),
        .pop       (ring_status.admit),
        .full      (fifo_full),
        .not_empty (fifo_not_empty),
        .head_id   (fifo_id),
        .head_time (fifo_time)
    );

    rrjs_ready_ring #(
        .DEPTH  (RING_DEPTH),
        .ID_W   (ID_WIDTH),
        .TIME_W (TIME_WIDTH)
    ) u_ready_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .proc       (is_proc),
        .quantum    (quantum_reg),
        .wait_valid (fifo_not_empty),
        .wait_id    (fifo_id),
        .wait_time  (fifo_time),
        .stack_full (stk_full),
        .status     (ring_status),
        .tail_id    (ring_tail_id),
        .run_id     (ring_run_id),
        .run_time   (ring_run_time)
    );

    rrjs_done_stack #(
        .DEPTH (STACK_DEPTH),
        .ID_W  (ID_WIDTH)
    ) u_done_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (ring_status.retire),
        .push_id (ring_tail_id),
        .pop     (is_unld),
        .full    (stk_full),
        .empty   (stk_empty),
        .top_id  (stk_top)
    );

    // Fields that a result kind does not use are driven to zero.
    always_comb
    begin
        report_id_next = '0;
        remaining_next = '0;
        if (is_proc && !ring_status.idle)
        begin
            report_id_next = ring_run_id;
            remaining_next = ring_run_time;
        end
        else if (is_unld && !stk_empty)
        begin
            report_id_next = stk_top;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            kind_reg      <= cmd_reg;
            rejected_reg  <= is_load && fifo_full;
            idle_reg      <= is_proc && ring_status.idle;
            report_id_reg <= report_id_next;
            remaining_reg <= remaining_next;
            empty_reg     <= is_unld && stk_empty;
        end
    end

    assign id_out_ext   = {16'd0, report_id_reg};
    assign time_out_ext = {16'd0, remaining_reg};

    assign result_strobe  = strobe_reg;
    assign result_kind    = kind_reg;
    assign load_rejected  = rejected_reg;
    assign ring_idle      = idle_reg;
    assign report_id      = id_out_ext[15:0];
    assign remaining_time = time_out_ext[15:0];
    assign stack_empty    = empty_reg;

endmodule

/* sim/tb_round_robin_job_scheduler_top.sv */
module tb_round_robin_job_scheduler_top;
    import rrjs_pkg::*;

    // Store sizes of the scheduler under test. The predictor keeps its own copy of each store.
    localparam int WAIT_SLOTS  = 16;
    localparam int RING_SLOTS  = 16;
    localparam int STACK_SLOTS = 16;

    // The fourth command code is unused by the block. It must leave the state alone and
    // answer with a result whose kind is that same code.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // Clock period is 12 units. A taken request passes the request register and then the result
    // register before its result shows, so the drain margin covers any work still in flight.
    localparam int HALF_PERIOD   = 6;
    localparam int DRAIN_CYCLES  = 4;
    localparam int TIMEOUT_UNITS = 12 * 300000;

    // One request as the driver presents it.
    typedef struct {
        logic [1:0]  op;
        logic [15:0] id;
        logic [15:0] tm;
    } sched_request_t;

    // One job as it sits in the waiting FIFO or in the ready ring.
    typedef struct {
        logic [15:0] id;
        logic [15:0] tm;
    } job_t;

    // One result, field for field as it appears on the result ports.
    typedef struct {
        logic [1:0]  kind;
        logic        rejected;
        logic        idle;
        logic [15:0] id;
        logic [15:0] rem;
        logic        empty;
    } sched_report_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic [1:0]  cmd       = CMD_LOAD;
    logic [15:0] job_id    = 16'd0;
    logic [15:0] job_time  = 16'd0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        busy;
    logic        result_strobe;
    logic [1:0]  result_kind;
    logic        load_rejected;
    logic        ring_idle;
    logic [15:0] report_id;
    logic [15:0] remaining_time;
    logic        stack_empty;

    // Requests that the stimulus has produced and the driver has not yet presented.
    sched_request_t pending_requests[$];
    // Results predicted for requests that were taken, oldest first.
    sched_report_t  expected_reports[$];

    // Share of cycles in which the driver holds back a request, in percent.
    int unsigned idle_pct = 0;
    // Set at each rising edge when the request on the ports was taken there.
    bit          req_taken = 1'b0;
    int unsigned n_queued = 0;
    int unsigned n_accepted = 0;
    int unsigned n_checked = 0;
    int unsigned n_errors = 0;

    // Predictor state. It starts at the reset values and follows every taken request and
    // every quantum write.
    logic [15:0] quantum_now = 16'd1;
    job_t        wait_fifo[WAIT_SLOTS];
    int unsigned wait_count = 0;
    int unsigned wait_rd = 0;
    job_t        ready_ring[RING_SLOTS];
    int unsigned ring_head = 0;
    int unsigned ring_count = 0;
    logic [15:0] done_stack[STACK_SLOTS];
    int unsigned stack_count = 0;

    sched_request_t next_req;
    sched_report_t  want;

    round_robin_job_scheduler_top #(
        .WAIT_DEPTH  (WAIT_SLOTS),
        .RING_DEPTH  (RING_SLOTS),
        .STACK_DEPTH (STACK_SLOTS),
        .ID_WIDTH    (16),
        .TIME_WIDTH  (16)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .job_id         (job_id),
        .job_time       (job_time),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .result_strobe  (result_strobe),
        .result_kind    (result_kind),
        .load_rejected  (load_rejected),
        .ring_idle      (ring_idle),
        .report_id      (report_id),
        .remaining_time (remaining_time),
        .stack_empty    (stack_empty)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Works one request through the predictor state and returns the result it must produce.
    // A process command first retires a finished job at the ring tail into the done stack,
    // then admits one waiting job at the ring tail, and finally runs the ring head for one
    // quantum (clamped at zero), reports it and rotates it to the tail.
    function automatic sched_report_t advance_scheduler(sched_request_t rq);
        sched_report_t rpt;
        int unsigned   slot;
        job_t          job;

        rpt = '{kind: rq.op, rejected: 1'b0, idle: 1'b0, id: 16'd0, rem: 16'd0, empty: 1'b0};
        case (rq.op)
            CMD_LOAD:
            begin
                if (wait_count >= WAIT_SLOTS)
                    rpt.rejected = 1'b1;
                else
                begin
                    slot = (wait_rd + wait_count) % WAIT_SLOTS;
                    wait_fifo[slot] = '{id: rq.id, tm: rq.tm};
                    wait_count++;
                end
            end
            CMD_PROC:
            begin
                // A finished tail job stays in the ring while the done stack is full.
                if (ring_count > 0)
                begin
                    slot = (ring_head + ring_count - 1) % RING_SLOTS;
                    if (ready_ring[slot].tm == 16'd0 && stack_count < STACK_SLOTS)
                    begin
                        done_stack[stack_count] = ready_ring[slot].id;
                        stack_count++;
                        ring_count--;
                    end
                end
                // A waiting job stays in the FIFO while the ring is full.
                if (wait_count > 0 && ring_count < RING_SLOTS)
                begin
                    job = wait_fifo[wait_rd];
                    wait_rd = (wait_rd + 1) % WAIT_SLOTS;
                    wait_count--;
                    ready_ring[(ring_head + ring_count) % RING_SLOTS] = job;
                    ring_count++;
                end
                if (ring_count == 0)
                    rpt.idle = 1'b1;
                else
                begin
                    job = ready_ring[ring_head];
                    job.tm = (job.tm <= quantum_now) ? 16'd0 : job.tm - quantum_now;
                    rpt.id = job.id;
                    rpt.rem = job.tm;
                    ready_ring[(ring_head + ring_count) % RING_SLOTS] = job;
                    ring_head = (ring_head + 1) % RING_SLOTS;
                end
            end
            CMD_UNLD:
            begin
                if (stack_count == 0)
                    rpt.empty = 1'b1;
                else
                begin
                    stack_count--;
                    rpt.id = done_stack[stack_count];
                end
            end
            default:
            begin
                // The spare code changes nothing; all fields but the kind stay zero.
            end
        endcase
        return rpt;
    endfunction

    task automatic check_field(string label, logic [15:0] want_v, logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, actual %0d", label, want_v, got_v);
            n_errors++;
        end
    endtask

    // Driver. A request stays on the ports until it is taken; only then does the next one
    // appear, or start drops when the queue is empty or the sender idles this cycle.
    always @(negedge clk)
    begin
        if (rst_n && (!start || req_taken))
        begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                next_req = pending_requests.pop_front();
                start    <= 1'b1;
                cmd      <= next_req.op;
                job_id   <= next_req.id;
                job_time <= next_req.tm;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor. It checks any result on the ports against the oldest prediction, follows
    // quantum writes, and predicts the result of a request taken at this edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_strobe)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("result with no request waiting: kind %0d, id %0d",
                           result_kind, report_id);
                    n_errors++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("result_kind", 16'(want.kind), 16'(result_kind));
                    check_field("load_rejected", 16'(want.rejected), 16'(load_rejected));
                    check_field("ring_idle", 16'(want.idle), 16'(ring_idle));
                    check_field("report_id", want.id, report_id);
                    check_field("remaining_time", want.rem, remaining_time);
                    check_field("stack_empty", 16'(want.empty), 16'(stack_empty));
                    n_checked++;
                end
            end
            if (cfg_we)
                quantum_now = cfg_wdata;
            req_taken = start && !busy;
            if (req_taken)
            begin
                expected_reports.push_back(advance_scheduler('{op: cmd, id: job_id,
                                                               tm: job_time}));
                n_accepted++;
            end
        end
    end

    task automatic queue_request(logic [1:0] op, logic [15:0] id, logic [15:0] tm);
        pending_requests.push_back('{op: op, id: id, tm: tm});
        n_queued++;
    endtask

    // Job times lean small so that jobs finish and retire often, with the quantum edges, the
    // field extremes and the full range mixed in.
    function automatic logic [15:0] pick_job_time();
        int unsigned r;

        r = $urandom_range(0, 99);
        if (r < 55)
            return 16'($urandom_range(0, 4));
        else if (r < 80)
            return 16'($urandom_range(0, 64));
        else if (r < 85)
            return quantum_now;
        else if (r < 90)
            return quantum_now + 16'd1;
        else if (r < 95)
            return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        else
            return 16'($urandom_range(0, 65535));
    endfunction

    // Random traffic comes in bursts of one kind, so the waiting FIFO, the ring and the done
    // stack each get filled to the brim and drained again. A share of mixed bursts carries
    // all four command codes in any order.
    task automatic queue_random_traffic(int unsigned count);
        int unsigned made;
        int unsigned burst;
        int unsigned len;
        int unsigned k;
        logic [1:0]  op;

        made = 0;
        while (made < count)
        begin
            burst = $urandom_range(0, 99);
            len = (burst >= 30 && burst < 65) ? $urandom_range(1, 40) : $urandom_range(1, 20);
            for (k = 0; k < len && made < count; k++)
            begin
                if (burst < 30)
                    op = CMD_LOAD;
                else if (burst < 65)
                    op = CMD_PROC;
                else if (burst < 85)
                    op = CMD_UNLD;
                else
                    op = 2'($urandom_range(0, 3));
                queue_request(op, 16'($urandom_range(0, 65535)), pick_job_time());
                made++;
            end
        end
    endtask

    // Returns once every queued request has been taken and answered, plus the latency margin.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (n_accepted != n_queued || n_checked != n_accepted);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_quantum(logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Drains the block, sets the quantum and the sender's idle rate, then sends the traffic.
    task automatic run_phase(logic [15:0] quantum, int unsigned idle, int unsigned count);
        wait_drained();
        write_quantum(quantum);
        idle_pct = idle;
        queue_random_traffic(count);
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening with the reset quantum written once more: empty stack on unload,
        // empty ring on process, the spare code, field extremes, a zero-time job that is
        // clamped, retired and unloaded, and a job running far longer than the quantum.
        write_quantum(16'd1);
        queue_request(CMD_UNLD, 16'hFFFF, 16'hFFFF);
        queue_request(CMD_PROC, 16'hFFFF, 16'hFFFF);
        queue_request(CMD_SPARE, 16'h0000, 16'h0000);
        queue_request(CMD_LOAD, 16'hFFFF, 16'hFFFF);
        queue_request(CMD_LOAD, 16'h0000, 16'h0000);
        queue_request(CMD_LOAD, 16'h5A5A, 16'h0001);
        queue_request(CMD_LOAD, 16'hA5A5, 16'h0002);
        repeat (8) queue_request(CMD_PROC, 16'h0000, 16'h0000);
        repeat (3) queue_request(CMD_UNLD, 16'h0000, 16'h0000);
        queue_request(CMD_SPARE, 16'hFFFF, 16'hFFFF);
        queue_request(CMD_LOAD, 16'h0001, 16'h0000);
        queue_random_traffic(450);

        // Each phase leaves the queues as they are and only changes the quantum and the pace.
        // The largest quantum finishes every job at once, a zero quantum lets only zero-time
        // jobs finish so the ring fills up, and small ones mix both.
        run_phase(16'hFFFF, 85, 450);
        run_phase(16'h0000, 0, 400);
        run_phase(16'($urandom_range(2, 9)), 14, 450);
        run_phase(16'($urandom_range(0, 65535)), 0, 250);

        wait_drained();
        if (expected_reports.size() != 0)
        begin
            $error("%0d predicted results never arrived", expected_reports.size());
            n_errors++;
        end
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #TIMEOUT_UNITS;
        $display("FAIL");
        $finish;
    end

endmodule
